FILE: rtl/nca_pkg.sv
// Shared types and constants for the nearest-centroid assignment core.
// No dependencies; every other file imports this package.
package nca_pkg;

   localparam int VALUE_W        = 16;
   localparam int IDX_W          = 4;
   localparam int ACC_W          = 37;
   localparam int DIST_W         = 36;
   localparam int SQ_W           = 32;
   localparam int NCLUST_W       = 5;
   localparam int FIELD_CLUSTERS = 16;

   localparam logic [NCLUST_W-1:0] NUM_CLUSTERS_RESET = 5'd2;

   // command codes
   localparam logic CMD_LOAD  = 1'b0;
   localparam logic CMD_POINT = 1'b1;

   // one transaction as it travels down the cell chain
   typedef struct packed {
      logic                      valid;
      logic                      cmd;
      logic [IDX_W-1:0]          cluster_index;
      logic [IDX_W-1:0]          feature_index;
      logic signed [VALUE_W-1:0] value;
      logic                      last_feature;
   } item_type;

   // running nearest-centroid decision handed from cell to cell
   typedef struct packed {
      logic               valid;
      logic [IDX_W-1:0]   cluster;
      logic [ACC_W-1:0]   distance;
   } best_type;

   // point feature after the centroid read
   typedef struct packed {
      logic                      valid;
      logic                      last_feature;
      logic                      in_range;
      logic signed [VALUE_W-1:0] value;
   } stage_type;

endpackage

FILE: rtl/nca_if.sv
// Valid/ready channel interfaces for request and response transactions.
// Depends on nca_pkg.
interface nca_req_if import nca_pkg::*; ();
   logic                      valid;
   logic                      ready;
   logic                      cmd;
   logic [IDX_W-1:0]          cluster_index;
   logic [IDX_W-1:0]          feature_index;
   logic signed [VALUE_W-1:0] value;
   logic                      last_feature;

   modport source (output valid, cmd, cluster_index, feature_index, value, last_feature,
                   input ready);
   modport sink   (input valid, cmd, cluster_index, feature_index, value, last_feature,
                   output ready);
endinterface

interface nca_rsp_if import nca_pkg::*; ();
   logic                    valid;
   logic                    ready;
   logic [IDX_W-1:0]        cluster;
   logic [DIST_W-1:0]       distance;

   modport source (output valid, cluster, distance, input ready);
   modport sink   (input valid, cluster, distance, output ready);
endinterface

FILE: rtl/nca_cell.sv
// One centroid cell: centroid row memory, squared-difference pipeline,
// distance accumulator and the running-minimum compare. Depends on nca_pkg.
module nca_cell import nca_pkg::*; #(
   parameter int MAX_FEATURES = 16,
   parameter int CELL_INDEX   = 0
) (
   input  logic     clock,
   input  logic     reset,
   input  logic     en,
   input  logic     cell_active,
   input  item_type item_in,
   input  best_type best_in,
   output item_type item_out,
   output best_type best_out
);

   localparam int FEAT_AW = (MAX_FEATURES > 1) ? $clog2(MAX_FEATURES) : 1;

   logic signed [VALUE_W-1:0] row_mem [MAX_FEATURES];
   logic signed [VALUE_W-1:0] rd_ff;
   logic [FEAT_AW-1:0]        addr;
   logic                      in_range;
   logic                      wr;

   item_type                  item_ff;
   stage_type                 s1_ff, s1_in;
   logic                      s2_valid_ff, s2_last_ff;
   logic [SQ_W-1:0]           sq_ff, sq_in;
   logic signed [VALUE_W:0]   diff;
   logic signed [2*VALUE_W+1:0] prod;
   logic [ACC_W-1:0]          acc_ff, acc_in, acc_sum;
   best_type                  best_ff, best_in_nxt;
   logic                      take;

   // address decode and load match
   assign in_range = 32'(item_in.feature_index) < MAX_FEATURES;
   assign addr     = FEAT_AW'(item_in.feature_index);
   assign wr       = item_in.valid && item_in.cmd == CMD_LOAD && in_range &&
                     item_in.cluster_index == IDX_W'(CELL_INDEX);

   // centroid row: write on load, registered read for every transaction
   always_ff @(posedge clock) begin
      if (en) begin
         if (wr) row_mem[addr] <= item_in.value;
         rd_ff <= row_mem[addr];
      end
   end

   assign s1_in.valid        = item_in.valid && item_in.cmd == CMD_POINT;
   assign s1_in.last_feature = item_in.last_feature;
   assign s1_in.in_range     = in_range;
   assign s1_in.value        = item_in.value;

   // squared difference; out-of-range features contribute zero
   assign diff  = {s1_ff.value[VALUE_W-1], s1_ff.value} - {rd_ff[VALUE_W-1], rd_ff};
   assign prod  = diff * diff;
   assign sq_in = s1_ff.in_range ? prod[SQ_W-1:0] : '0;

   // accumulate and compare against the decision from the previous cell
   assign acc_sum = acc_ff + ACC_W'(sq_ff);
   assign take    = cell_active && acc_sum < best_in.distance;

   always_comb begin
      acc_in               = acc_ff;
      best_in_nxt.valid    = s2_valid_ff && s2_last_ff;
      best_in_nxt.cluster  = take ? IDX_W'(CELL_INDEX) : best_in.cluster;
      best_in_nxt.distance = take ? acc_sum : best_in.distance;
      if (s2_valid_ff) begin
         acc_in = s2_last_ff ? '0 : acc_sum;
      end
   end

   // pipeline stages and accumulator; only valid bits and the accumulator reset
   always_ff @(posedge clock) begin
      if (reset) begin
         item_ff.valid <= 1'b0;
         s1_ff.valid   <= 1'b0;
         s2_valid_ff   <= 1'b0;
         best_ff.valid <= 1'b0;
         acc_ff        <= '0;
      end else if (en) begin
         item_ff.valid         <= item_in.valid;
         s1_ff.valid           <= s1_in.valid;
         s2_valid_ff           <= s1_ff.valid;
         best_ff.valid         <= best_in_nxt.valid;
         acc_ff                <= acc_in;
         item_ff.cmd           <= item_in.cmd;
         item_ff.cluster_index <= item_in.cluster_index;
         item_ff.feature_index <= item_in.feature_index;
         item_ff.value         <= item_in.value;
         item_ff.last_feature  <= item_in.last_feature;
         s1_ff.last_feature    <= s1_in.last_feature;
         s1_ff.in_range        <= s1_in.in_range;
         s1_ff.value           <= s1_in.value;
         s2_last_ff            <= s1_ff.last_feature;
         sq_ff                 <= sq_in;
         best_ff.cluster       <= best_in_nxt.cluster;
         best_ff.distance      <= best_in_nxt.distance;
      end
   end

   assign item_out = item_ff;
   assign best_out = best_ff;

endmodule

FILE: rtl/nearest_centroid_assign_core.sv
// Nearest-centroid assignment core: a chain of centroid cells, one per cluster.
// One transaction per cycle unless stalled; each cell advances one hop per cycle.
// A waiting response stalls the chain only when the next response reaches the tail.
// Reset (synchronous): accumulators zero, num_clusters = 2; centroid memory unset.
// Depends on nca_pkg, nca_if and nca_cell.
module nearest_centroid_assign_core import nca_pkg::*; #(
   parameter int MAX_CLUSTERS = 16,
   parameter int MAX_FEATURES = 16
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                csr_write_enable,
   input  logic [NCLUST_W-1:0] csr_write_data,
   nca_req_if.sink             req_chan,
   nca_rsp_if.source           rsp_chan
);

   localparam int NUM_CELLS = (MAX_CLUSTERS < FIELD_CLUSTERS) ? MAX_CLUSTERS : FIELD_CLUSTERS;

   logic [NCLUST_W-1:0] num_clusters_ff;
   logic [NCLUST_W-1:0] kmax;
   logic                en;
   logic                tail_valid;

   item_type            chain_item_in  [NUM_CELLS];
   item_type            chain_item_out [NUM_CELLS];
   best_type            chain_best_in  [NUM_CELLS];
   best_type            chain_best_out [NUM_CELLS];
   logic [NUM_CELLS-1:0] cell_active;

   logic                rsp_valid_ff;
   logic [IDX_W-1:0]    rsp_cluster_ff;
   logic [DIST_W-1:0]   rsp_distance_ff;

   // configuration register
   always_ff @(posedge clock) begin
      if (reset) begin
         num_clusters_ff <= NUM_CLUSTERS_RESET;
      end else if (csr_write_enable) begin
         num_clusters_ff <= csr_write_data;
      end
   end

   // clusters compared: zero acts as one, capped at the cell count
   always_comb begin
      kmax = num_clusters_ff;
      if (num_clusters_ff == '0) kmax = NCLUST_W'(1);
      else if (num_clusters_ff > NCLUST_W'(NUM_CELLS)) kmax = NCLUST_W'(NUM_CELLS);
   end

   // chain advances unless a new result would overwrite a waiting one
   assign tail_valid     = chain_best_out[NUM_CELLS-1].valid;
   assign en             = !(rsp_valid_ff && !rsp_chan.ready && tail_valid);
   assign req_chan.ready = en;

   // cell chain
   for (genvar k = 0; k < NUM_CELLS; k++) begin : g_cell
      assign cell_active[k] = NCLUST_W'(k) < kmax;

      if (k == 0) begin : g_head
         assign chain_item_in[k].valid         = req_chan.valid;
         assign chain_item_in[k].cmd           = req_chan.cmd;
         assign chain_item_in[k].cluster_index = req_chan.cluster_index;
         assign chain_item_in[k].feature_index = req_chan.feature_index;
         assign chain_item_in[k].value         = req_chan.value;
         assign chain_item_in[k].last_feature  = req_chan.last_feature;
         assign chain_best_in[k].valid         = 1'b0;
         assign chain_best_in[k].cluster       = '0;
         assign chain_best_in[k].distance      = '1;
      end else begin : g_link
         assign chain_item_in[k] = chain_item_out[k-1];
         assign chain_best_in[k] = chain_best_out[k-1];
      end

      nca_cell #(
         .MAX_FEATURES (MAX_FEATURES),
         .CELL_INDEX   (k)
      ) u_cell (
         .clock       (clock),
         .reset       (reset),
         .en          (en),
         .cell_active (cell_active[k]),
         .item_in     (chain_item_in[k]),
         .best_in     (chain_best_in[k]),
         .item_out    (chain_item_out[k]),
         .best_out    (chain_best_out[k])
      );
   end

   // response register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (en && tail_valid) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (en && tail_valid) begin
         rsp_cluster_ff  <= chain_best_out[NUM_CELLS-1].cluster;
         rsp_distance_ff <= chain_best_out[NUM_CELLS-1].distance[DIST_W-1:0];
      end
   end

   assign rsp_chan.valid    = rsp_valid_ff;
   assign rsp_chan.cluster  = rsp_cluster_ff;
   assign rsp_chan.distance = rsp_distance_ff;

   // checks
   a_cluster_in_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> {1'b0, rsp_cluster_ff} < kmax)
      else $error("response cluster beyond active cluster count");

   a_rsp_from_tail: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(tail_valid) && $past(en))
      else $error("response raised without a result at the chain tail");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_chan.ready |=> rsp_valid_ff && $stable(rsp_distance_ff))
      else $error("waiting response overwritten or dropped");

   a_tail_item_seen: assert property (@(posedge clock) disable iff (reset)
      chain_item_out[NUM_CELLS-1].valid && !en |=> chain_item_out[NUM_CELLS-1].valid)
      else $error("transaction lost at chain tail during stall");

endmodule

FILE: test/nca_assign_checker.sv
`timescale 1ns / 1ps
// Passive checker for the nearest-centroid assignment core: watches both channels
// and the register port, predicts each assignment and compares it. Uses nca_pkg.
module nca_assign_checker import nca_pkg::*; (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      csr_write_enable,
   input  logic [NCLUST_W-1:0]       csr_write_data,
   input  logic                      req_valid,
   input  logic                      req_ready,
   input  logic                      req_cmd,
   input  logic [IDX_W-1:0]          req_cluster_index,
   input  logic [IDX_W-1:0]          req_feature_index,
   input  logic signed [VALUE_W-1:0] req_value,
   input  logic                      req_last_feature,
   input  logic                      rsp_valid,
   input  logic                      rsp_ready,
   input  logic [IDX_W-1:0]          rsp_cluster,
   input  logic [DIST_W-1:0]         rsp_distance,
   output int                        error_count,
   output int                        pending_count
);

   localparam int NUM_CELLS = 16;
   localparam int NUM_DIMS  = 16;
   localparam int SHOWN_MAX = 10;

   typedef struct {
      logic [IDX_W-1:0]  cluster;
      logic [DIST_W-1:0] distance;
   } assignment_t;

   logic signed [VALUE_W-1:0] centroid_mem [NUM_CELLS][NUM_DIMS];
   logic [ACC_W-1:0]          dist_acc [NUM_CELLS];
   logic [NCLUST_W-1:0]       cluster_setting;
   assignment_t               expected_assignments[$];
   int                        errors;

   initial begin
      error_count   = 0;
      pending_count = 0;
      errors        = 0;
   end

   // apply one accepted request transaction to the shadow state
   task automatic absorb_request();
      int               diff;
      longint           sq;
      int               active;
      int               best_k;
      logic [ACC_W-1:0] best_d;
      assignment_t      win;
      if (req_cmd == CMD_LOAD) begin
         centroid_mem[req_cluster_index][req_feature_index] = req_value;
         return;
      end
      // every centroid accumulates, whether in use or not
      for (int k = 0; k < NUM_CELLS; k++) begin
         diff = int'(req_value) - int'(centroid_mem[k][req_feature_index]);
         sq = longint'(diff) * longint'(diff);
         dist_acc[k] = dist_acc[k] + sq[ACC_W-1:0];
      end
      if (!req_last_feature)
         return;
      // zero acts as one, anything above the cell count is capped
      active = int'(cluster_setting);
      if (active == 0)
         active = 1;
      if (active > NUM_CELLS)
         active = NUM_CELLS;
      best_k = 0;
      best_d = dist_acc[0];
      for (int k = 1; k < active; k++) begin
         if (dist_acc[k] < best_d) begin
            best_d = dist_acc[k];
            best_k = k;
         end
      end
      win.cluster  = IDX_W'(best_k);
      win.distance = best_d[DIST_W-1:0];
      expected_assignments.push_back(win);
      for (int k = 0; k < NUM_CELLS; k++)
         dist_acc[k] = '0;
   endtask

   // compare one accepted response transaction with the oldest prediction
   task automatic check_response();
      assignment_t want;
      if (expected_assignments.size() == 0) begin
         if (errors < SHOWN_MAX)
            $display("unexpected response: cluster %0d distance %0d",
                     rsp_cluster, rsp_distance);
         errors++;
         return;
      end
      want = expected_assignments.pop_front();
      if (rsp_cluster !== want.cluster || rsp_distance !== want.distance) begin
         if (errors < SHOWN_MAX)
            $display("mismatch: expected cluster %0d distance %0d, got cluster %0d distance %0d",
                     want.cluster, want.distance, rsp_cluster, rsp_distance);
         errors++;
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < NUM_CELLS; k++)
            dist_acc[k] = '0;
         cluster_setting = NUM_CLUSTERS_RESET;
         expected_assignments.delete();
      end else begin
         if (csr_write_enable)
            cluster_setting = csr_write_data;
         if (req_valid && req_ready)
            absorb_request();
         if (rsp_valid && rsp_ready)
            check_response();
      end
      error_count   <= errors;
      pending_count <= expected_assignments.size();
   end

endmodule

FILE: test/tb_top.sv
`timescale 1ns / 1ps
// Top of the nearest-centroid assignment testbench: clock, reset, stimulus and verdict.
// Depends on nca_pkg, nca_if, nearest_centroid_assign_core and nca_assign_checker.
module tb_top import nca_pkg::*; ();

   localparam int CYCLE_LIMIT     = 400000;
   localparam int DRAIN_CYCLES    = 30;
   localparam int ITEMS_PER_PHASE = 40;
   localparam int NUM_PHASES      = 8;
   localparam logic signed [VALUE_W-1:0] VMAX = 16'sh7fff;
   localparam logic signed [VALUE_W-1:0] VMIN = 16'sh8000;

   logic                clock;
   logic                reset;
   logic                csr_write_enable;
   logic [NCLUST_W-1:0] csr_write_data;
   int                  error_count;
   int                  pending_count;
   int                  cycle_count;
   int                  send_idle_pct;
   int                  recv_stall_pct;
   int                  items_sent;

   // cluster 0 row as loaded, used to aim long points at overflow
   logic signed [VALUE_W-1:0] row0_shadow [16];

   nca_req_if req_chan ();
   nca_rsp_if rsp_chan ();

   nearest_centroid_assign_core dut (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .req_chan         (req_chan),
      .rsp_chan         (rsp_chan)
   );

   nca_assign_checker assign_check (
      .clock             (clock),
      .reset             (reset),
      .csr_write_enable  (csr_write_enable),
      .csr_write_data    (csr_write_data),
      .req_valid         (req_chan.valid),
      .req_ready         (req_chan.ready),
      .req_cmd           (req_chan.cmd),
      .req_cluster_index (req_chan.cluster_index),
      .req_feature_index (req_chan.feature_index),
      .req_value         (req_chan.value),
      .req_last_feature  (req_chan.last_feature),
      .rsp_valid         (rsp_chan.valid),
      .rsp_ready         (rsp_chan.ready),
      .rsp_cluster       (rsp_chan.cluster),
      .rsp_distance      (rsp_chan.distance),
      .error_count       (error_count),
      .pending_count     (pending_count)
   );

   initial clock = 1'b0;
   always #10 clock = ~clock;

   // watchdog
   initial cycle_count = 0;
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

   // receiver back-pressure
   always @(posedge clock) begin
      if (reset)
         rsp_chan.ready <= 1'b0;
      else
         rsp_chan.ready <= ($urandom_range(99) >= recv_stall_pct);
   end

   function automatic logic signed [VALUE_W-1:0] pick_value();
      case ($urandom_range(7))
         0: return VMIN;
         1: return VMAX;
         2: return 16'sh0000;
         3: return 16'shffff;
         default: return VALUE_W'($urandom_range(65535));
      endcase
   endfunction

   // one request transaction, preceded by random sender idle cycles
   task automatic send_req(input logic cmd, input logic [IDX_W-1:0] ci,
                           input logic [IDX_W-1:0] fi,
                           input logic signed [VALUE_W-1:0] val, input logic last);
      while ($urandom_range(99) < send_idle_pct) begin
         req_chan.valid <= 1'b0;
         @(posedge clock);
      end
      req_chan.valid         <= 1'b1;
      req_chan.cmd           <= cmd;
      req_chan.cluster_index <= ci;
      req_chan.feature_index <= fi;
      req_chan.value         <= val;
      req_chan.last_feature  <= last;
      @(posedge clock);
      while (!req_chan.ready)
         @(posedge clock);
      if (cmd == CMD_LOAD && ci == 0)
         row0_shadow[fi] = val;
      items_sent++;
   endtask

   // a point of len features; wrap steers every feature far from centroid 0
   task automatic send_point(input int len, input bit wrap);
      logic [IDX_W-1:0]          fi;
      logic signed [VALUE_W-1:0] val;
      bit                        scattered;
      scattered = ($urandom_range(99) < 30);
      for (int n = 0; n < len; n++) begin
         fi = scattered ? IDX_W'($urandom_range(15)) : IDX_W'(n);
         if (wrap)
            val = row0_shadow[fi][VALUE_W-1] ? VMAX : VMIN;
         else
            val = pick_value();
         send_req(CMD_POINT, IDX_W'($urandom_range(15)), fi, val, n == len - 1);
      end
   endtask

   task automatic random_sequence();
      int pick;
      pick = $urandom_range(99);
      if (pick < 18)
         send_req(CMD_LOAD, IDX_W'($urandom_range(15)), IDX_W'($urandom_range(15)),
                  pick_value(), 1'($urandom_range(1)));
      else if (pick < 21)
         send_point($urandom_range(30, 40), 1'b1);
      else if ($urandom_range(99) < 70)
         send_point($urandom_range(1, 6), 1'b0);
      else
         send_point($urandom_range(7, 16), 1'b0);
   endtask

   // wait until every predicted response is back and the chain has emptied
   task automatic drain();
      req_chan.valid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_clusters(input logic [NCLUST_W-1:0] setting);
      csr_write_enable <= 1'b1;
      csr_write_data   <= setting;
      @(posedge clock);
      csr_write_enable <= 1'b0;
   endtask

   initial begin
      int cfg_plan [NUM_PHASES];
      cfg_plan = '{1, 16, 0, 31, 2, 17, 3, 9};
      cfg_plan[6] = $urandom_range(1, 16);
      cfg_plan[7] = $urandom_range(1, 16);
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      items_sent     = 0;
      reset                  <= 1'b1;
      csr_write_enable       <= 1'b0;
      csr_write_data         <= '0;
      req_chan.valid         <= 1'b0;
      req_chan.cmd           <= CMD_LOAD;
      req_chan.cluster_index <= '0;
      req_chan.feature_index <= '0;
      req_chan.value         <= '0;
      req_chan.last_feature  <= 1'b0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // fill the whole table so that no point reads an unwritten element
      for (int c = 0; c < 16; c++)
         for (int f = 0; f < 16; f++)
            send_req(CMD_LOAD, IDX_W'(c), IDX_W'(f), VMIN, 1'b0);

      // full-length point at the far corner: every centroid ties, largest distance
      for (int f = 0; f < 16; f++)
         send_req(CMD_POINT, 4'hf, IDX_W'(f), VMAX, f == 15);
      // load with the last flag set gives nothing
      send_req(CMD_LOAD, 4'd1, 4'd0, VMAX, 1'b1);
      send_req(CMD_POINT, 4'd0, 4'd0, VMAX, 1'b1);
      // same feature twice in one point
      send_req(CMD_POINT, 4'd0, 4'd0, VMIN, 1'b0);
      send_req(CMD_POINT, 4'd0, 4'd0, 16'sh0000, 1'b1);
      // a closer centroid outside the reset cluster count is not chosen
      send_req(CMD_LOAD, 4'hf, 4'hf, 16'sh0000, 1'b0);
      send_req(CMD_POINT, 4'h0, 4'hf, 16'sh0000, 1'b1);

      for (int p = 0; p < NUM_PHASES; p++) begin
         drain();
         write_clusters(NCLUST_W'(cfg_plan[p]));
         case (p % 4)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 48; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 48; end
            default: begin send_idle_pct = 38; recv_stall_pct = 38; end
         endcase
         items_sent = 0;
         while (items_sent < ITEMS_PER_PHASE)
            random_sequence();
      end

      drain();
      if (error_count == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

endmodule
